### rtl/core/sigpf_pkg.sv
// ----------------------------------------------------------------------------
// sigpf_pkg
// Shared types and constants for the idle-gap serial packet framer.
// ----------------------------------------------------------------------------
package sigpf_pkg;

  localparam int BUF_DEPTH = 64;
  localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int LEN_W     = 7;
  localparam int GAP_W     = 8;
  localparam int BYTE_W    = 8;

  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(5);
  localparam logic [GAP_W-1:0] GAP_MIN   = GAP_W'(1);
  localparam logic [GAP_W-1:0] GAP_MAX   = GAP_W'(250);

  // request modes
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic [LEN_W-1:0]  packet_length;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic in_fire;     // request accepted this cycle
    logic start_read;  // begin streaming the stored packet
    logic issue;       // read next byte from the store
    logic load;        // move read data into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pkt_ready;   // packet complete and not empty
    logic rd_more;     // bytes left to fetch
    logic q_valid;     // store read data waiting
    logic out_valid;   // output register occupied
  } status_t;

endpackage

### rtl/core/sigpf_ram.sv
// ----------------------------------------------------------------------------
// sigpf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sigpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/sigpf_ctrl.sv
// ----------------------------------------------------------------------------
// sigpf_ctrl
// Controller: request acceptance and packet read streaming sequence.
// ----------------------------------------------------------------------------
module sigpf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic               out_ready,
  input  sigpf_pkg::status_t st_i,
  output sigpf_pkg::cmd_t    cmd_o
);
  import sigpf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_free;

  assign out_free = !st_i.out_valid || out_ready;

  always_comb begin
    in_ready         = (state_r == ST_IDLE) && out_free;
    cmd_o.in_fire    = in_valid && in_ready;
    cmd_o.start_read = cmd_o.in_fire && (in_mode == MODE_READ) && st_i.pkt_ready;
    cmd_o.load       = st_i.q_valid && out_free;
    // keep one read in flight; refill as soon as the pending byte moves on
    cmd_o.issue      = (state_r == ST_STREAM) && st_i.rd_more
                       && (!st_i.q_valid || cmd_o.load);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_o.start_read) begin
          state_nxt = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (!st_i.rd_more && (!st_i.q_valid || cmd_o.load)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_no_fire_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !st_i.q_valid)
    else $error("request accepted while store data pending");

  a_issue_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.issue |=> st_i.q_valid)
    else $error("store read issued without data following");

  a_load_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load |=> st_i.out_valid)
    else $error("output register not filled after load");

endmodule

### rtl/core/sigpf_dp.sv
// ----------------------------------------------------------------------------
// sigpf_dp
// Datapath: gap register, write index, gap counter, packet store, output stage.
// ----------------------------------------------------------------------------
module sigpf_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sigpf_pkg::in_item_t          in_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output sigpf_pkg::out_item_t         out_data,
  input  logic                         cfg_we,
  input  logic [sigpf_pkg::GAP_W-1:0]  cfg_wdata,
  input  sigpf_pkg::cmd_t              cmd_i,
  output sigpf_pkg::status_t           st_o
);
  import sigpf_pkg::*;

  logic [GAP_W-1:0]  gap_r;
  logic [LEN_W-1:0]  widx_r, widx_nxt;
  logic [GAP_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [LEN_W-1:0]  rd_len_r, rd_len_nxt;
  logic              q_valid_r, q_valid_nxt;
  logic              q_last_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [GAP_W-1:0]  g_eff, g_p1, g_p2, cnt_inc;
  logic              complete, store_we, single_res;
  logic [BYTE_W-1:0] ram_q;
  out_item_t         single_item;

  always_comb begin
    g_eff = gap_r;
    if (gap_r < GAP_MIN) begin
      g_eff = GAP_MIN;
    end else if (gap_r > GAP_MAX) begin
      g_eff = GAP_MAX;
    end
    g_p1    = g_eff + GAP_W'(1);
    g_p2    = g_eff + GAP_W'(2);
    cnt_inc = cnt_r + GAP_W'(1);
  end

  assign complete = (cnt_r >= g_p1);
  assign store_we = cmd_i.in_fire && (in_data.mode == MODE_BYTE)
                    && (widx_r < LEN_W'(BUF_DEPTH));

  always_comb begin
    widx_nxt    = widx_r;
    cnt_nxt     = cnt_r;
    rd_idx_nxt  = rd_idx_r;
    rd_len_nxt  = rd_len_r;
    single_res  = 1'b0;
    single_item = '0;

    if (cmd_i.in_fire) begin
      unique case (in_data.mode)
        MODE_BYTE: begin
          if (store_we) begin
            widx_nxt = widx_r + LEN_W'(1);
          end
          cnt_nxt = GAP_W'(1);
        end
        MODE_TICK: begin
          if ((cnt_r != '0) && (cnt_r < g_p2)) begin
            cnt_nxt = cnt_inc;
            if (cnt_inc == g_p1) begin
              single_res                = 1'b1;
              single_item.result_kind   = KIND_EVENT;
              single_item.packet_length = widx_r;
            end
          end
        end
        MODE_READ: begin
          if (!complete || (widx_r == '0)) begin
            single_res              = 1'b1;
            single_item.result_kind = KIND_EMPTY;
            single_item.last_byte   = 1'b1;
          end
          if (complete) begin
            rd_len_nxt = widx_r;
            rd_idx_nxt = '0;
            widx_nxt   = '0;
            cnt_nxt    = '0;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.issue) begin
      rd_idx_nxt = rd_idx_r + LEN_W'(1);
    end
  end

  sigpf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (widx_r[ADDR_W-1:0]),
    .wdata (in_data.rx_byte),
    .re    (cmd_i.issue),
    .raddr (rd_idx_r[ADDR_W-1:0]),
    .rdata (ram_q)
  );

  always_comb begin
    q_valid_nxt = q_valid_r;
    if (cmd_i.issue) begin
      q_valid_nxt = 1'b1;
    end else if (cmd_i.load) begin
      q_valid_nxt = 1'b0;
    end

    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (cmd_i.load) begin
      out_nxt.result_kind   = KIND_BYTE;
      out_nxt.data_byte     = ram_q;
      out_nxt.last_byte     = q_last_r;
      out_nxt.packet_length = rd_len_r;
      out_valid_nxt         = 1'b1;
    end else if (single_res) begin
      out_nxt       = single_item;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r       <= GAP_RESET;
      widx_r      <= '0;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      rd_len_r    <= '0;
      q_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        gap_r <= cfg_wdata;
      end
      widx_r      <= widx_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_len_r    <= rd_len_nxt;
      q_valid_r   <= q_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.issue) begin
      q_last_r <= (rd_idx_r + LEN_W'(1) == rd_len_r);
    end
    out_r <= out_nxt;
  end

  always_comb begin
    st_o.pkt_ready = complete && (widx_r != '0);
    st_o.rd_more   = (rd_idx_r != rd_len_r);
    st_o.q_valid   = q_valid_r;
    st_o.out_valid = out_valid_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_i.load && single_res))
    else $error("output register loaded from two sources");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.start_read |=> (widx_r == '0) && (cnt_r == '0) && st_o.rd_more)
    else $error("packet read did not clear index and counter");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (widx_r <= LEN_W'(BUF_DEPTH)) && (rd_idx_r <= rd_len_r))
    else $error("index out of range");

endmodule

### rtl/core/serial_idle_gap_packet_framer.sv
// ----------------------------------------------------------------------------
// serial_idle_gap_packet_framer
// Frames received serial bytes into packets separated by an idle gap.
//
//   channel  ports                          carries
//   in       in_valid/in_ready/in_data      byte, timer tick or read request
//   out      out_valid/out_ready/out_data   frame event, packet byte, no-packet
//   cfg      cfg_we/cfg_wdata               gap_ticks, written immediately
//
// Requests are taken only while no read streams; an event or no-packet answer
// waits in the output register and the next request is taken once it is free.
// A read streams its bytes from the registered store read data through the
// output register, one per cycle unless stalled, and stalls lose nothing.
// Reset is synchronous; the store is not cleared, only bytes written since the
// last packet read are ever read.
// ----------------------------------------------------------------------------
module serial_idle_gap_packet_framer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sigpf_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sigpf_pkg::out_item_t         out_data,
  input  logic                         cfg_we,
  input  logic [sigpf_pkg::GAP_W-1:0]  cfg_wdata
);
  import sigpf_pkg::*;

  cmd_t    cmd;
  status_t st;

  sigpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_data.mode),
    .out_ready (out_ready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  sigpf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_i     (cmd),
    .st_o      (st)
  );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the idle-gap serial packet framer. Bytes, timer
// ticks and read requests go in over a valid/ready channel; a scoreboard
// class predicts frame events, packet bytes and no-packet answers and checks
// every result in order. The gap register is rewritten between phases,
// covering its clamped extremes.
// ----------------------------------------------------------------------------
module tb;
  import sigpf_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 2000;

  class frame_scoreboard;
    logic [BYTE_W-1:0] held_bytes [BUF_DEPTH];
    logic [LEN_W-1:0]  fill;
    logic [GAP_W-1:0]  gap_count;
    logic [GAP_W-1:0]  gap_reg;
    out_item_t         pending_results [$];
    int                errors;

    function new();
      fill      = '0;
      gap_count = '0;
      gap_reg   = GAP_RESET;
      errors    = 0;
    endfunction

    function void set_gap(logic [GAP_W-1:0] value);
      gap_reg = value;
    endfunction

    // register value as the block uses it
    function int eff_gap();
      if (gap_reg < GAP_MIN) return GAP_MIN;
      if (gap_reg > GAP_MAX) return GAP_MAX;
      return gap_reg;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void push_result(logic [1:0] kind, logic [BYTE_W-1:0] data, logic last,
                              logic [LEN_W-1:0] len);
      out_item_t r;
      r.result_kind   = kind;
      r.data_byte     = data;
      r.last_byte     = last;
      r.packet_length = len;
      pending_results.push_back(r);
    endfunction

    function void predict_request(in_item_t req);
      int g;
      int n;
      g = eff_gap();
      case (req.mode)
        MODE_BYTE: begin
          // a full store drops the byte but the gap still restarts
          if (fill < BUF_DEPTH) begin
            held_bytes[fill[ADDR_W-1:0]] = req.rx_byte;
            fill++;
          end
          gap_count = 8'd1;
        end
        MODE_TICK: begin
          if (gap_count != 0 && gap_count < g + 2) begin
            gap_count++;
            if (gap_count == g + 1) push_result(KIND_EVENT, '0, 1'b0, fill);
          end
        end
        MODE_READ: begin
          if (gap_count < g + 1) begin
            push_result(KIND_EMPTY, '0, 1'b1, '0);
          end else begin
            n         = fill;
            fill      = '0;
            gap_count = '0;
            if (n == 0) push_result(KIND_EMPTY, '0, 1'b1, '0);
            for (int i = 0; i < n; i++)
              push_result(KIND_BYTE, held_bytes[i], (i + 1 == n), LEN_W'(n));
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d data %0h last %0d len %0d",
               got.result_kind, got.data_byte, got.last_byte, got.packet_length);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
        errors++;
      end
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
        errors++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last_byte: expected %0d, got %0d", want.last_byte, got.last_byte);
        errors++;
      end
      if (got.packet_length !== want.packet_length) begin
        $error("packet_length: expected %0d, got %0d", want.packet_length,
               got.packet_length);
        errors++;
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [GAP_W-1:0] cfg_wdata = '0;

  frame_scoreboard sb;
  int  stall_cycles  = 0;
  int  sent_count    = 0;
  int  tx_idle_pct   = 0;
  int  rx_idle_pct   = 0;
  bit  hold_pending  = 1'b0;

  serial_idle_gap_packet_framer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // requests are predicted before results are checked within one edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_gap(cfg_wdata);
      if (in_valid && in_ready) sb.predict_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if ($urandom_range(1, 100) <= rx_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send(input logic [1:0] mode_v, input logic [BYTE_W-1:0] byte_v);
    in_item_t req;
    req.mode    = mode_v;
    req.rx_byte = byte_v;
    if ($urandom_range(1, 100) <= tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    if (mode_v != MODE_UNUSED) sent_count++;
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) send(MODE_TICK, 8'($urandom));
  endtask

  // drain everything, then wait and drain again until no results remain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    do begin
      while (sb.outstanding() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (sb.outstanding() != 0);
  endtask

  task automatic write_gap(input logic [GAP_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly well-formed packets: bytes, idle ticks, read; some noise and
  // short gaps so that reads land before completion
  task automatic packet_sequence();
    int g;
    int r;
    int n;
    int t;
    g = sb.eff_gap();
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send(2'($urandom), 8'($urandom));
      return;
    end
    n = (r < 18) ? $urandom_range(60, 70) : $urandom_range(1, 8);
    for (int i = 0; i < n; i++) send(MODE_BYTE, 8'($urandom));
    if ($urandom_range(0, 4) == 0) send(MODE_READ, 8'($urandom));
    case ($urandom_range(0, 5))
      0:       t = $urandom_range(0, g);
      1:       t = g + 1 + $urandom_range(1, 4);
      default: t = g + 1;
    endcase
    for (int i = 0; i < t; i++) begin
      if ($urandom_range(0, 9) == 0) send(MODE_UNUSED, 8'($urandom));
      send(MODE_TICK, 8'($urandom));
    end
    if ($urandom_range(0, 9) != 0) send(MODE_READ, 8'($urandom));
  endtask

  task automatic run_phase(input logic [GAP_W-1:0] gap, input int budget,
                           input int tx_pct, input int rx_pct);
    int stop_at;
    write_gap(gap);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at     = sent_count + budget;
    while (sent_count < stop_at) packet_sequence();
  endtask

  initial begin : stimulus
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gap of 5; idle tick, early reads, unused mode
    send(MODE_TICK, 8'h00);
    send(MODE_READ, 8'h00);
    send(MODE_UNUSED, 8'hFF);
    send(MODE_BYTE, 8'h00);
    send(MODE_BYTE, 8'hFF);
    send(MODE_READ, 8'hFF);
    send_ticks(5);
    send_ticks(2);           // counter saturates, no second event
    send(MODE_READ, 8'h00);

    // zero gap behaves as one
    write_gap(8'd0);
    send(MODE_BYTE, 8'hA5);
    send(MODE_TICK, 8'hFF);
    send(MODE_READ, 8'h00);

    // lowering the gap under a saturated counter: it holds and stays complete
    write_gap(8'd3);
    send(MODE_BYTE, 8'h5A);
    send_ticks(4);
    write_gap(8'd1);
    send(MODE_TICK, 8'h00);
    send(MODE_READ, 8'hFF);

    // long receiver hold while a full packet is offered
    write_gap(8'd2);
    hold_pending = 1'b1;
    for (int i = 0; i < 5; i++) send(MODE_BYTE, 8'($urandom));
    send_ticks(3);
    send(MODE_READ, 8'($urandom));

    // gap above the top of the range: a few ticks leave the packet open
    write_gap(8'd255);
    send(MODE_BYTE, 8'($urandom));
    send_ticks(3);
    send(MODE_READ, 8'($urandom));

    run_phase(8'd2, 40, 25, 25);
    run_phase(8'd1, 40, 0,  30);
    run_phase(8'd6, 40, 30, 0);
    run_phase(8'd0, 40, 20, 20);
    run_phase(8'd3, 40, 0,  0);

    settle();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/sigpf_pkg.sv
rtl/core/sigpf_ram.sv
rtl/core/sigpf_ctrl.sv
rtl/core/sigpf_dp.sv
rtl/core/serial_idle_gap_packet_framer.sv
verif/tb.sv
